// File: rtl/tpes_pkg.sv
// ----------------------------------------------------------------------------
// tpes_pkg
// Shared types and constants for the timed priority event scheduler: field
// widths, operation codes and the record kept for each event slot.
// ----------------------------------------------------------------------------
package tpes_pkg;

	// field widths of the request and response items
	localparam int OP_W    = 3;
	localparam int TIME_W  = 64;
	localparam int SLOT_FW = 4;
	localparam int TYPE_W  = 32;
	localparam int PRIO_W  = 32;
	localparam int TAG_W   = 16;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 3'd0,
		OP_REMOVE   = 3'd1,
		OP_POSTPONE = 3'd2,
		OP_GET_NEXT = 3'd3,
		OP_TIME     = 3'd4
	} tpes_op_t;

	// slot contents other than the due time
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TYPE_W-1:0] ev_type;
		logic [TAG_W-1:0]  tag;
	} tpes_info_t;

	// outcome of the shared compare unit
	typedef struct packed {
		logic time_le;
		logic prio_gt;
	} tpes_cmp_t;

endpackage

// File: rtl/tpes_req_if.sv
// ----------------------------------------------------------------------------
// tpes_req_if
// Request channel: valid/ready handshake carrying one scheduler command item.
// ----------------------------------------------------------------------------
interface tpes_req_if
	import tpes_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [TIME_W-1:0] current_time;
	logic [SLOT_FW-1:0] event_slot;
	logic [TYPE_W-1:0] event_type;
	logic [PRIO_W-1:0] event_priority;
	logic [TIME_W-1:0] event_time;
	logic [TAG_W-1:0]  event_tag;

	modport source (
		output valid, opcode, current_time, event_slot, event_type,
		       event_priority, event_time, event_tag,
		input  ready
	);

	modport sink (
		input  valid, opcode, current_time, event_slot, event_type,
		       event_priority, event_time, event_tag,
		output ready
	);
endinterface

// File: rtl/tpes_rsp_if.sv
// ----------------------------------------------------------------------------
// tpes_rsp_if
// Response channel: valid/ready handshake carrying one scheduler result item.
// ----------------------------------------------------------------------------
interface tpes_rsp_if
	import tpes_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               found;
	logic [SLOT_FW-1:0] out_slot;
	logic [TYPE_W-1:0]  out_type;
	logic [PRIO_W-1:0]  out_priority;
	logic [TAG_W-1:0]   out_tag;
	logic [TIME_W-1:0]  wait_time;
	logic               wait_infinite;

	modport source (
		output valid, found, out_slot, out_type, out_priority, out_tag,
		       wait_time, wait_infinite,
		input  ready
	);

	modport sink (
		input  valid, found, out_slot, out_type, out_priority, out_tag,
		       wait_time, wait_infinite,
		output ready
	);
endinterface

// File: rtl/tpes_cmp.sv
// ----------------------------------------------------------------------------
// tpes_cmp
// Shared compare unit: one 64-bit time compare and one priority compare,
// reused by every step of the slot scan and by add and postpone.
// ----------------------------------------------------------------------------
module tpes_cmp
	import tpes_pkg::*;
(
	input  logic [TIME_W-1:0] time_a,
	input  logic [TIME_W-1:0] time_b,
	input  logic [PRIO_W-1:0] prio_a,
	input  logic [PRIO_W-1:0] prio_b,
	output tpes_cmp_t         res
);

	// a not after b, and a strictly above b
	always_comb begin
		res.time_le = (time_a <= time_b);
		res.prio_gt = (prio_a > prio_b);
	end

endmodule

// File: rtl/timed_priority_event_scheduler_unit.sv
// Add, remove and postpone go through the execute and done states.
// Get next and time until next go through execute, scan, drain and done:
// one slot record is read from the slot memory and compared per cycle.
// One item is in flight at a time; a held result does not block acceptance.
// Reset (arst_n low, asynchronous) clears all queued and due marks;
// slot records are undefined until written by add.
// ----------------------------------------------------------------------------
// timed_priority_event_scheduler_unit
// Event slot table with timed and due events; pops the highest priority due
// event and reports the time until the earliest event, by a sequential scan.
// ----------------------------------------------------------------------------
module timed_priority_event_scheduler_unit
	import tpes_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	tpes_req_if.sink  req,
	tpes_rsp_if.source rsp
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;

	// latched request item
	tpes_op_t          op_q;
	logic [TIME_W-1:0] now_q;
	logic [SLOT_W-1:0] slot_q;
	logic              slot_ok_q;
	tpes_info_t        info_in_q;
	logic [TIME_W-1:0] time_in_q;

	// per-slot marks
	logic [NUM_SLOTS-1:0] queued_q;
	logic [NUM_SLOTS-1:0] due_q;

	// slot memories
	logic [TIME_W-1:0] time_mem [NUM_SLOTS];
	tpes_info_t        info_mem [NUM_SLOTS];

	// scan control and read pipeline
	logic [SLOT_W-1:0] cnt_q;
	logic              rd_en;
	logic              rd_valid_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic [TIME_W-1:0] time_rd_s1;
	tpes_info_t        info_rd_s1;

	// scan accumulators
	logic              have_q;
	logic [SLOT_W-1:0] best_idx_q;
	tpes_info_t        best_q;
	logic              any_due_q;
	logic              any_timed_q;
	logic [TIME_W-1:0] earliest_q;

	// output register
	logic               out_valid_q;
	logic               found_q;
	logic [SLOT_FW-1:0] out_slot_q;
	logic [TYPE_W-1:0]  out_type_q;
	logic [PRIO_W-1:0]  out_prio_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [TIME_W-1:0]  wait_time_q;
	logic               wait_inf_q;

	logic              accept;
	logic              out_free;
	logic [TIME_W-1:0] cmp_time_a;
	logic [TIME_W-1:0] cmp_time_b;
	tpes_cmp_t         cmp;
	logic [TIME_W:0]   diff;
	logic              scan_queued;
	logic              scan_due;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || rsp.ready;
	assign rd_en    = (state_q == ST_SCAN);

	assign scan_queued = queued_q[idx_s1];
	assign scan_due    = due_q[idx_s1];

	// operand selection for the shared compare unit
	always_comb begin
		cmp_time_a = time_rd_s1;
		cmp_time_b = now_q;
		if (state_q == ST_EXEC) begin
			cmp_time_a = time_in_q;
		end else if (op_q == OP_TIME) begin
			cmp_time_a = earliest_q;
			cmp_time_b = time_rd_s1;
		end
	end

	tpes_cmp u_cmp (
		.time_a (cmp_time_a),
		.time_b (cmp_time_b),
		.prio_a (info_rd_s1.prio),
		.prio_b (best_q.prio),
		.res    (cmp)
	);

	// remaining time; borrow means the earliest time has passed
	assign diff = {1'b0, earliest_q} - {1'b0, now_q};

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q              <= tpes_op_t'(req.opcode);
			now_q             <= req.current_time;
			slot_q            <= SLOT_W'(req.event_slot);
			slot_ok_q         <= (32'(req.event_slot) < NUM_SLOTS);
			info_in_q.prio    <= req.event_priority;
			info_in_q.ev_type <= req.event_type;
			info_in_q.tag     <= req.event_tag;
			time_in_q         <= req.event_time;
		end
	end

	// slot memory write
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && slot_ok_q) begin
			if (op_q == OP_ADD) begin
				time_mem[slot_q] <= time_in_q;
				info_mem[slot_q] <= info_in_q;
			end else if (op_q == OP_POSTPONE) begin
				time_mem[slot_q] <= time_in_q;
			end
		end
	end

	// slot memory read, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			time_rd_s1 <= time_mem[cnt_q];
			info_rd_s1 <= info_mem[cnt_q];
			idx_s1     <= cnt_q;
		end
	end

	// sequencer, slot marks, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			queued_q    <= '0;
			due_q       <= '0;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			have_q      <= 1'b0;
			best_idx_q  <= '0;
			best_q      <= '0;
			any_due_q   <= 1'b0;
			any_timed_q <= 1'b0;
			earliest_q  <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			out_slot_q  <= '0;
			out_type_q  <= '0;
			out_prio_q  <= '0;
			out_tag_q   <= '0;
			wait_time_q <= '0;
			wait_inf_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;

			// result handed over
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			// one record per cycle out of the read stage
			if (rd_valid_s1 && scan_queued) begin
				if (op_q == OP_GET_NEXT) begin
					if (!scan_due && cmp.time_le) begin
						due_q[idx_s1] <= 1'b1;
					end
					if ((scan_due || cmp.time_le) && (!have_q || cmp.prio_gt)) begin
						have_q     <= 1'b1;
						best_idx_q <= idx_s1;
						best_q     <= info_rd_s1;
					end
				end else begin
					if (scan_due) begin
						any_due_q <= 1'b1;
					end else if (!any_timed_q || !cmp.time_le) begin
						any_timed_q <= 1'b1;
						earliest_q  <= time_rd_s1;
					end
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					have_q      <= 1'b0;
					any_due_q   <= 1'b0;
					any_timed_q <= 1'b0;
					cnt_q       <= '0;
					state_q     <= ST_DONE;
					case (op_q)
						OP_ADD, OP_POSTPONE: begin
							if (slot_ok_q) begin
								queued_q[slot_q] <= 1'b1;
								due_q[slot_q]    <= cmp.time_le;
							end
						end
						OP_REMOVE: begin
							if (slot_ok_q) begin
								queued_q[slot_q] <= 1'b0;
								due_q[slot_q]    <= 1'b0;
							end
						end
						OP_GET_NEXT, OP_TIME: begin
							state_q <= ST_SCAN;
						end
						default: begin
						end
					endcase
				end

				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SLOT_W'(NUM_SLOTS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end

				ST_DRAIN: begin
					state_q <= ST_DONE;
				end

				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						found_q     <= 1'b0;
						out_slot_q  <= '0;
						out_type_q  <= '0;
						out_prio_q  <= '0;
						out_tag_q   <= '0;
						wait_time_q <= '0;
						wait_inf_q  <= 1'b0;
						if (op_q == OP_GET_NEXT && have_q) begin
							// pop the winning slot
							queued_q[best_idx_q] <= 1'b0;
							due_q[best_idx_q]    <= 1'b0;
							found_q    <= 1'b1;
							out_slot_q <= SLOT_FW'(best_idx_q);
							out_type_q <= best_q.ev_type;
							out_prio_q <= best_q.prio;
							out_tag_q  <= best_q.tag;
						end else if (op_q == OP_TIME) begin
							if (any_due_q) begin
								wait_time_q <= '0;
							end else if (any_timed_q) begin
								wait_time_q <= diff[TIME_W] ? '0 : diff[TIME_W-1:0];
							end else begin
								wait_time_q <= '1;
								wait_inf_q  <= 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// response channel
	assign rsp.valid         = out_valid_q;
	assign rsp.found         = found_q;
	assign rsp.out_slot      = out_slot_q;
	assign rsp.out_type      = out_type_q;
	assign rsp.out_priority  = out_prio_q;
	assign rsp.out_tag       = out_tag_q;
	assign rsp.wait_time     = wait_time_q;
	assign rsp.wait_infinite = wait_inf_q;

endmodule

// File: tb/sv/tpes_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpes_tb_pkg
// Command and response records for the event scheduler bench, and a shadow
// of the slot table that works out each response and checks the block's.
// ----------------------------------------------------------------------------
package tpes_tb_pkg;
	import tpes_pkg::*;

	localparam int SLOTS = 16;

	// opcodes with no operation behind them
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [TIME_W-1:0]  now;
		logic [SLOT_FW-1:0] slot;
		logic [TYPE_W-1:0]  ev_type;
		logic [PRIO_W-1:0]  prio;
		logic [TIME_W-1:0]  ev_time;
		logic [TAG_W-1:0]   tag;
	} sched_cmd_t;

	typedef struct {
		logic               found;
		logic [SLOT_FW-1:0] slot;
		logic [TYPE_W-1:0]  ev_type;
		logic [PRIO_W-1:0]  prio;
		logic [TAG_W-1:0]   tag;
		logic [TIME_W-1:0]  wait_time;
		logic               wait_inf;
	} sched_rsp_t;

	class event_table_shadow;
		bit                queued [SLOTS];
		bit                due    [SLOTS];
		logic [TIME_W-1:0] due_at [SLOTS];
		tpes_info_t        info   [SLOTS];
		sched_rsp_t        awaited[$];
		int unsigned       failures;

		function new();
			foreach (queued[i]) begin
				queued[i] = 1'b0;
				due[i]    = 1'b0;
				due_at[i] = '0;
				info[i]   = '0;
			end
			failures = 0;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		// apply one accepted command to the table and queue its response
		function void accept_command(sched_cmd_t c);
			sched_rsp_t        r;
			int                best;
			bit                any_due;
			bit                any_timed;
			logic [TIME_W-1:0] earliest;
			r = '{default: '0};
			case (c.op)
				OP_ADD: begin
					info[c.slot]   = '{prio: c.prio, ev_type: c.ev_type, tag: c.tag};
					due_at[c.slot] = c.ev_time;
					queued[c.slot] = 1'b1;
					due[c.slot]    = (c.ev_time <= c.now);
				end
				OP_REMOVE: begin
					queued[c.slot] = 1'b0;
					due[c.slot]    = 1'b0;
				end
				OP_POSTPONE: begin
					due_at[c.slot] = c.ev_time;
					queued[c.slot] = 1'b1;
					due[c.slot]    = (c.ev_time <= c.now);
				end
				OP_GET_NEXT: begin
					best = -1;
					// expired timed events become due first
					for (int i = 0; i < SLOTS; i++) begin
						if (queued[i] && !due[i] && due_at[i] <= c.now)
							due[i] = 1'b1;
					end
					// strict compare keeps the lowest index on a tie
					for (int i = 0; i < SLOTS; i++) begin
						if (queued[i] && due[i] && (best < 0 || info[i].prio > info[best].prio))
							best = i;
					end
					if (best >= 0) begin
						queued[best] = 1'b0;
						due[best]    = 1'b0;
						r.found      = 1'b1;
						r.slot       = SLOT_FW'(best);
						r.ev_type    = info[best].ev_type;
						r.prio       = info[best].prio;
						r.tag        = info[best].tag;
					end
				end
				OP_TIME: begin
					any_due   = 1'b0;
					any_timed = 1'b0;
					earliest  = '0;
					for (int i = 0; i < SLOTS; i++) begin
						if (queued[i]) begin
							if (due[i]) begin
								any_due = 1'b1;
							end else if (!any_timed || due_at[i] < earliest) begin
								any_timed = 1'b1;
								earliest  = due_at[i];
							end
						end
					end
					if (any_due) begin
						r.wait_time = '0;
					end else if (any_timed) begin
						r.wait_time = (earliest > c.now) ? earliest - c.now : '0;
					end else begin
						r.wait_time = '1;
						r.wait_inf  = 1'b1;
					end
				end
				default: begin
				end
			endcase
			awaited.push_back(r);
		endfunction

		function void match_field(string name, logic [63:0] exp, logic [63:0] act);
			if (exp !== act) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
				failures++;
			end
		endfunction

		// compare one accepted response with the oldest one awaited
		function void check_response(sched_rsp_t got);
			sched_rsp_t exp;
			if (awaited.size() == 0) begin
				$display("%0t: response with none awaited, actual found %0b slot %0d wait %0h",
					$time, got.found, got.slot, got.wait_time);
				failures++;
				return;
			end
			exp = awaited.pop_front();
			match_field("found", exp.found, got.found);
			match_field("out_slot", exp.slot, got.slot);
			match_field("out_type", exp.ev_type, got.ev_type);
			match_field("out_priority", exp.prio, got.prio);
			match_field("out_tag", exp.tag, got.tag);
			match_field("wait_time", exp.wait_time, got.wait_time);
			match_field("wait_infinite", exp.wait_inf, got.wait_inf);
		endfunction
	endclass

endpackage

// File: tb/sv/tb_timed_priority_event_scheduler_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timed_priority_event_scheduler_unit
// Drives scheduler commands with random gaps and response stalls, first a
// directed set of corner cases, then random traffic built around a moving
// present time; every response is checked against a shadow slot table.
// ----------------------------------------------------------------------------
module tb_timed_priority_event_scheduler_unit;
	import tpes_pkg::*;
	import tpes_tb_pkg::*;

	localparam int          RANDOM_ITEMS = 1200;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	logic clk;
	logic arst_n;

	tpes_req_if req_ch ();
	tpes_rsp_if rsp_ch ();

	timed_priority_event_scheduler_unit #(
		.NUM_SLOTS(SLOTS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	event_table_shadow shadow = new();

	logic [TIME_W-1:0] sim_now;
	bit                slot_written [SLOTS];
	bit                send_steady;
	int unsigned       cycle_count = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic sched_cmd_t make_cmd(logic [OP_W-1:0] op, logic [TIME_W-1:0] now,
			logic [SLOT_FW-1:0] slot, logic [TYPE_W-1:0] ev_type, logic [PRIO_W-1:0] prio,
			logic [TIME_W-1:0] ev_time, logic [TAG_W-1:0] tag);
		sched_cmd_t c;
		c.op      = op;
		c.now     = now;
		c.slot    = slot;
		c.ev_type = ev_type;
		c.prio    = prio;
		c.ev_time = ev_time;
		c.tag     = tag;
		return c;
	endfunction

	// random command around a mostly advancing present time
	function automatic sched_cmd_t random_command();
		sched_cmd_t  c;
		int unsigned pick;
		int unsigned live [$];
		pick = $urandom_range(0, 99);
		if (pick < 90)
			sim_now = sim_now + $urandom_range(0, 20);
		else if (pick < 95)
			sim_now = {$urandom, $urandom};
		else
			sim_now = '1 - $urandom_range(0, 40);
		c.now     = sim_now;
		c.slot    = SLOT_FW'($urandom_range(0, SLOTS - 1));
		c.ev_type = $urandom;
		c.tag     = TAG_W'($urandom);
		// small priorities give plenty of ties
		pick = $urandom_range(0, 99);
		if (pick < 60)
			c.prio = $urandom_range(0, 7);
		else if (pick < 80)
			c.prio = $urandom;
		else if (pick < 90)
			c.prio = '0;
		else
			c.prio = '1;
		// due times mostly near now, some already passed
		pick = $urandom_range(0, 99);
		if (pick < 65)
			c.ev_time = sim_now + $urandom_range(0, 60) - 10;
		else if (pick < 75)
			c.ev_time = sim_now;
		else if (pick < 85)
			c.ev_time = {$urandom, $urandom};
		else if (pick < 92)
			c.ev_time = '0;
		else
			c.ev_time = '1;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			c.op = OP_ADD;
		else if (pick < 40)
			c.op = OP_REMOVE;
		else if (pick < 55)
			c.op = OP_POSTPONE;
		else if (pick < 80)
			c.op = OP_GET_NEXT;
		else if (pick < 95)
			c.op = OP_TIME;
		else
			c.op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
		// removals mostly hit live slots
		if (c.op == OP_REMOVE && $urandom_range(0, 9) < 7) begin
			foreach (shadow.queued[i])
				if (shadow.queued[i]) live.push_back(i);
			if (live.size() != 0) c.slot = SLOT_FW'(live[$urandom_range(0, live.size() - 1)]);
		end
		// postpone only slots that already hold a record
		if (c.op == OP_POSTPONE) begin
			live.delete();
			foreach (slot_written[i])
				if (slot_written[i]) live.push_back(i);
			if (live.size() == 0)
				c.op = OP_ADD;
			else
				c.slot = SLOT_FW'(live[$urandom_range(0, live.size() - 1)]);
		end
		if (c.op == OP_ADD) slot_written[c.slot] = 1'b1;
		return c;
	endfunction

	// present one command and wait for its handshake
	task automatic send_command(sched_cmd_t c);
		int unsigned gap;
		gap = send_steady ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.opcode         <= c.op;
		req_ch.current_time   <= c.now;
		req_ch.event_slot     <= c.slot;
		req_ch.event_type     <= c.ev_type;
		req_ch.event_priority <= c.prio;
		req_ch.event_time     <= c.ev_time;
		req_ch.event_tag      <= c.tag;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		shadow.accept_command(c);
	endtask

	// hold off until every awaited response is in
	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (shadow.pending() != 0);
	endtask

	// response side with random stalls
	initial begin : response_sink
		int unsigned stall;
		int unsigned taken;
		bit          steady;
		sched_rsp_t  got;
		taken  = 0;
		steady = 1'b0;
		forever begin
			if (taken % 40 == 0) steady = ($urandom_range(0, 3) == 0);
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			got.found     = rsp_ch.found;
			got.slot      = rsp_ch.out_slot;
			got.ev_type   = rsp_ch.out_type;
			got.prio      = rsp_ch.out_priority;
			got.tag       = rsp_ch.out_tag;
			got.wait_time = rsp_ch.wait_time;
			got.wait_inf  = rsp_ch.wait_infinite;
			shadow.check_response(got);
			taken++;
		end
	end

	// reset, directed corner cases, then random traffic
	initial begin : command_source
		sched_cmd_t plan [$];
		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.opcode         <= '0;
		req_ch.current_time   <= '0;
		req_ch.event_slot     <= '0;
		req_ch.event_type     <= '0;
		req_ch.event_priority <= '0;
		req_ch.event_time     <= '0;
		req_ch.event_tag      <= '0;
		sim_now     = '0;
		send_steady = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		plan.push_back(make_cmd(OP_TIME, '0, '0, '0, '0, '0, '0));
		plan.push_back(make_cmd(OP_GET_NEXT, '0, '0, '0, '0, '0, '0));
		// one timed event, queried, too early, then expired
		plan.push_back(make_cmd(OP_ADD, 50, 0, 32'h1234_5678, 5, 100, 16'h00a5));
		plan.push_back(make_cmd(OP_TIME, 50, '1, '1, '1, '1, '1));
		plan.push_back(make_cmd(OP_GET_NEXT, 60, 0, 0, 0, 0, 0));
		plan.push_back(make_cmd(OP_GET_NEXT, 100, 0, 0, 0, 0, 0));
		// equal top priorities, lower slot goes first
		plan.push_back(make_cmd(OP_ADD, '0, 15, '1, '1, '0, '1));
		plan.push_back(make_cmd(OP_ADD, '0, 3, 32'hdead_beef, '1, '0, 16'h5a5a));
		plan.push_back(make_cmd(OP_TIME, '0, 0, 0, 0, 0, 0));
		plan.push_back(make_cmd(OP_GET_NEXT, '0, 0, 0, 0, 0, 0));
		// overwrite a queued slot with the latest possible time
		plan.push_back(make_cmd(OP_ADD, '0, 15, '0, 1, '1, '0));
		plan.push_back(make_cmd(OP_TIME, 10, 0, 0, 0, 0, 0));
		plan.push_back(make_cmd(OP_TIME, '1, 0, 0, 0, 0, 0));
		// remove a live slot and one never queued
		plan.push_back(make_cmd(OP_REMOVE, '0, 15, '1, '1, '1, '1));
		plan.push_back(make_cmd(OP_REMOVE, '0, 7, 0, 0, 0, 0));
		plan.push_back(make_cmd(OP_TIME, '0, 0, 0, 0, 0, 0));
		// postpone an unqueued slot, then a queued one into the past
		plan.push_back(make_cmd(OP_POSTPONE, 100, 0, 0, 0, 200, 0));
		plan.push_back(make_cmd(OP_TIME, 150, 0, 0, 0, 0, 0));
		plan.push_back(make_cmd(OP_POSTPONE, 300, 0, 0, 0, 150, 0));
		plan.push_back(make_cmd(OP_GET_NEXT, 300, 0, 0, 0, 0, 0));
		// timed event already passed but not yet made due
		plan.push_back(make_cmd(OP_ADD, 10, 2, 32'h0bad_cafe, 9, 50, 16'h8001));
		plan.push_back(make_cmd(OP_TIME, 80, 0, 0, 0, 0, 0));
		plan.push_back(make_cmd(OP_GET_NEXT, 80, 0, 0, 0, 0, 0));
		// opcodes with no operation
		plan.push_back(make_cmd(OP_SPARE_A, '1, '1, '1, '1, '1, '1));
		plan.push_back(make_cmd(OP_SPARE_B, 0, 0, 0, 0, 0, 0));
		plan.push_back(make_cmd(OP_SPARE_C, 0, 0, 0, 0, 0, 0));
		foreach (plan[i]) begin
			if (plan[i].op == OP_ADD) slot_written[plan[i].slot] = 1'b1;
			send_command(plan[i]);
		end
		drain_responses();

		sim_now = 1000;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) send_steady = ($urandom_range(0, 3) == 0);
			if (n % 400 == 399) drain_responses();
			send_command(random_command());
		end
		drain_responses();
		repeat (40) @(posedge clk);

		if (shadow.failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/tpes_pkg.sv
rtl/tpes_req_if.sv
rtl/tpes_rsp_if.sv
rtl/tpes_cmp.sv
rtl/timed_priority_event_scheduler_unit.sv
tb/sv/tpes_tb_pkg.sv
tb/sv/tb_timed_priority_event_scheduler_unit.sv
